FILE: rtl/csi_pkg.sv
// Shared types, constants and helpers of the constrained spline interpolator.
`default_nettype none
package csi_pkg;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned WIDE_W = 64;
    localparam logic [WIDE_W-1:0] LIM62 = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [WIDE_W-1:0] LIM31 = 64'h0000_0000_7FFF_FFFF;

    // Item codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [0:0] REG_TRIM  = 1'b0;
    localparam logic [0:0] REG_COUNT = 1'b1;

    // One queued item between the front and the back.
    typedef struct packed {
        logic        command;
        logic [3:0]  knot_index;
        logic [31:0] knot_x;
        logic [31:0] knot_y;
        logic [31:0] query_x;
    } item_t;

    // Clamp a wide signed value to +-lim.
    function automatic logic signed [WIDE_W-1:0] clamp_sym(
        input logic signed [WIDE_W+1:0] v,
        input logic [WIDE_W-1:0] lim
    );
        logic signed [WIDE_W+1:0] hi;
        logic signed [WIDE_W+1:0] lo;
        hi = $signed({2'b00, lim});
        lo = -hi;
        if (v > hi)
            clamp_sym = hi[WIDE_W-1:0];
        else if (v < lo)
            clamp_sym = lo[WIDE_W-1:0];
        else
            clamp_sym = v[WIDE_W-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/csi_if.sv
// Valid/ready channel interfaces of the spline interpolator.
`default_nettype none
interface csi_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [3:0]  knot_index;
    logic signed [31:0] knot_x;
    logic signed [31:0] knot_y;
    logic signed [31:0] query_x;
    modport source (output valid, command, knot_index, knot_x, knot_y, query_x,
                    input ready);
    modport sink (input valid, command, knot_index, knot_x, knot_y, query_x,
                  output ready);
endinterface

interface csi_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] value;
    modport source (output valid, value, input ready);
    modport sink (input valid, value, output ready);
endinterface
`default_nettype wire

FILE: rtl/constrained_spline_interpolator.sv
// Top level of the constrained cubic spline interpolator.
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        command, knot_index, knot_x, knot_y, query_x
//  out_ch    out  valid/ready        value
//  apb       in   psel/penable       trim_enable (0x0), knot_count (0x4)
//
// A knot write is taken by the engine only while it is idle. A query that trim
// clamps needs no division. Otherwise the interval search reads one knot after
// another, and each of up to eight multiply-divides runs in the shared divider.
// Reset clears control state; the knot tables hold no value until written.
// The result register parts the two sides; a queue of two items lets input
// continue while the engine is busy.
`default_nettype none
module constrained_spline_interpolator #(
    parameter int unsigned MAX_KNOTS = 16,
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    csi_in_if.sink      in_ch,
    csi_out_if.source   out_ch,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic trim_enable_reg;
    logic [4:0] knot_count_reg;
    logic item_valid;
    logic item_take;
    csi_pkg::item_t item;

    assign pready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_enable_reg <= 1'b1;
            knot_count_reg  <= 5'd16;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                csi_pkg::REG_TRIM:  trim_enable_reg <= pwdata[0];
                csi_pkg::REG_COUNT: knot_count_reg  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            csi_pkg::REG_TRIM:  prdata = {31'd0, trim_enable_reg};
            csi_pkg::REG_COUNT: prdata = {27'd0, knot_count_reg};
            default:            prdata = '0;
        endcase
    end

    csi_front #(.QUEUE_DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .item_valid(item_valid),
        .item(item), .item_take(item_take));

    csi_back #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .trim_enable(trim_enable_reg),
        .knot_count(knot_count_reg), .item_valid(item_valid), .item(item),
        .item_take(item_take), .out_ch(out_ch));

    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[2] == csi_pkg::REG_COUNT) |=>
        knot_count_reg == $past(pwdata[4:0]))
        else $error("knot count write lost");
endmodule
`default_nettype wire

FILE: rtl/csi_ram.sv
// Generic single-write, registered-read RAM.
`default_nettype none
module csi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/csi_div.sv
// Iterative unit: trunc(a*b/c) saturated to +-(2^62-1), one quotient bit a cycle.
`default_nettype none
module csi_div (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire  [63:0] a,
    input  wire  [63:0] b,
    input  wire  [63:0] c,
    output logic        done,
    output logic [63:0] q
);
    typedef enum logic [2:0] {D_IDLE, D_MUL0, D_MUL1, D_MUL2, D_MUL3, D_DIV,
                              D_FIN} dstate_t;
    dstate_t state_reg;
    logic        neg_reg;
    logic        over_reg;
    logic        zero_reg;
    logic [63:0] ua_reg;
    logic [63:0] ub_reg;
    logic [63:0] uc_reg;
    logic [127:0] prod_reg;
    logic [63:0] r_reg;
    logic [63:0] q_reg;
    logic [6:0]  k_reg;
    logic [63:0] pp;
    logic [31:0] m_a;
    logic [31:0] m_b;
    logic [63:0] r_sh;
    logic        carry;
    logic        take;

    // Partial products: one 32x32 multiplier shared over the states D_MUL0 to D_MUL3.
    always_comb
    begin
        case (state_reg)
            D_MUL0:  begin m_a = ua_reg[31:0];  m_b = ub_reg[31:0];  end
            D_MUL1:  begin m_a = ua_reg[63:32]; m_b = ub_reg[31:0];  end
            D_MUL2:  begin m_a = ua_reg[31:0];  m_b = ub_reg[63:32]; end
            default: begin m_a = ua_reg[63:32]; m_b = ub_reg[63:32]; end
        endcase
        pp = {32'd0, m_a} * {32'd0, m_b};
    end

    // Restoring division step.
    always_comb
    begin
        carry = r_reg[63];
        r_sh  = {r_reg[62:0], prod_reg[127]};
        take  = carry || (r_sh >= uc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg  <= (a[63] ^ b[63]) ^ c[63];
                        ua_reg   <= a[63] ? (64'd0 - a) : a;
                        ub_reg   <= b[63] ? (64'd0 - b) : b;
                        uc_reg   <= c[63] ? (64'd0 - c) : c;
                        zero_reg <= (c == 64'd0);
                        prod_reg <= '0;
                        r_reg    <= '0;
                        q_reg    <= '0;
                        over_reg <= 1'b0;
                        k_reg    <= 7'd127;
                        state_reg <= D_MUL0;
                    end
                end
                D_MUL0:
                begin
                    prod_reg  <= prod_reg + {64'd0, pp};
                    state_reg <= D_MUL1;
                end
                D_MUL1:
                begin
                    prod_reg  <= prod_reg + {32'd0, pp, 32'd0};
                    state_reg <= D_MUL2;
                end
                D_MUL2:
                begin
                    prod_reg  <= prod_reg + {32'd0, pp, 32'd0};
                    state_reg <= D_MUL3;
                end
                D_MUL3:
                begin
                    prod_reg  <= prod_reg + {pp, 64'd0};
                    state_reg <= D_DIV;
                end
                D_DIV:
                begin
                    prod_reg <= {prod_reg[126:0], 1'b0};
                    r_reg    <= take ? (r_sh - uc_reg) : r_sh;
                    q_reg    <= {q_reg[62:0], take};
                    if (q_reg[63])
                        over_reg <= 1'b1;
                    k_reg <= k_reg - 7'd1;
                    if (k_reg == 7'd0)
                        state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    if (zero_reg)
                        q <= '0;
                    else if (over_reg || (q_reg > csi_pkg::LIM62))
                        q <= neg_reg ? (64'd0 - csi_pkg::LIM62) : csi_pkg::LIM62;
                    else
                        q <= neg_reg ? (64'd0 - q_reg) : q_reg;
                    done      <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                    state_reg <= D_IDLE;
            endcase
        end
    end

    // The unit reports completion only after running a full pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == D_FIN)
        else $error("divider done without finishing");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_DIV) |=> (state_reg == D_DIV || state_reg == D_FIN))
        else $error("divider left the division loop early");
endmodule
`default_nettype wire

FILE: rtl/csi_front.sv
// Front part: accepts items and queues them for the evaluation engine.
`default_nettype none
module csi_front #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire          clk,
    input  wire          rst_n,
    csi_in_if.sink       in_ch,
    output logic         item_valid,
    output csi_pkg::item_t item,
    input  wire          item_take
);
    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    csi_pkg::item_t q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W:0]   cnt_reg;
    logic push;
    logic pop;

    assign in_ch.ready = (cnt_reg != QUEUE_DEPTH[PTR_W:0]);
    assign push = in_ch.valid && in_ch.ready;
    assign pop  = item_take && item_valid;
    assign item_valid = (cnt_reg != '0);
    assign item = q_reg[rd_reg];

    // Short queue between the two parts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg].command    <= in_ch.command;
            q_reg[wr_reg].knot_index <= in_ch.knot_index;
            q_reg[wr_reg].knot_x     <= in_ch.knot_x;
            q_reg[wr_reg].knot_y     <= in_ch.knot_y;
            q_reg[wr_reg].query_x    <= in_ch.query_x;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QUEUE_DEPTH[PTR_W:0])
        else $error("item queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("item queue count slip");
endmodule
`default_nettype wire

FILE: rtl/csi_back.sv
// Back part: table writes and the spline evaluation sequencer.
`default_nettype none
module csi_back #(
    parameter int unsigned MAX_KNOTS = 16,
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            trim_enable,
    input  wire [4:0]      knot_count,
    input  wire            item_valid,
    input  csi_pkg::item_t item,
    output logic           item_take,
    csi_out_if.source      out_ch
);
    localparam int unsigned AW = $clog2(MAX_KNOTS);
    localparam int unsigned CW = AW + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_RDW, S_SRCH, S_TRIM, S_LOAD, S_LOADW, S_LOADC,
        S_SLOPE, S_INNER, S_DERIV, S_COMB, S_EV1, S_EV2, S_EV3, S_SAT,
        S_DIVW, S_OUT
    } state_t;

    state_t state_reg;
    state_t ret_reg;
    logic signed [63:0] x0_reg, xl_reg, y0_reg, yl_reg;
    logic signed [63:0] xw_reg [4];
    logic signed [63:0] yw_reg [4];
    logic signed [63:0] sl_reg [3];
    logic signed [63:0] fl_reg, fr_reg, qx_reg, h_reg, u_reg;
    logic signed [63:0] bq_reg, cc_reg, s_reg, t0_reg;
    logic signed [63:0] acc_w;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] last_reg;
    logic [CW-1:0] step_reg;
    logic [2:0]    sub_reg;
    logic [AW-1:0] raddr;
    logic [31:0]   xr, yr;
    logic          div_start;
    logic [63:0]   div_a, div_b, div_c, div_q;
    logic          div_done;
    logic [CW-1:0] n_clamp;
    logic signed [31:0] value_reg;
    logic          ov_reg;
    logic          wr_en;
    logic signed [63:0] qx_w;
    logic signed [63:0] xr_w, yr_w;
    logic signed [63:0] one_fx;

    assign one_fx = 64'sd1 <<< FRAC_BITS;
    assign qx_w = {{32{item.query_x[31]}}, item.query_x};
    assign xr_w = {{32{xr[31]}}, xr};
    assign yr_w = {{32{yr[31]}}, yr};

    // Knot count saturates into the table range.
    always_comb
    begin
        if (knot_count < 5'd3)
            n_clamp = CW'(3);
        else if (32'(knot_count) > MAX_KNOTS)
            n_clamp = CW'(MAX_KNOTS);
        else
            n_clamp = CW'(knot_count);
    end

    // Writes to a slot beyond the table are dropped.
    assign wr_en = (state_reg == S_IDLE) && item_valid && !ov_reg &&
                   (item.command == csi_pkg::CMD_WRITE) &&
                   (32'(item.knot_index) < MAX_KNOTS);

    csi_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_xram (
        .clk(clk), .we(wr_en), .waddr(AW'(item.knot_index)),
        .wdata(item.knot_x), .raddr(raddr), .rdata(xr));
    csi_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_yram (
        .clk(clk), .we(wr_en), .waddr(AW'(item.knot_index)),
        .wdata(item.knot_y), .raddr(raddr), .rdata(yr));

    csi_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .a(div_a), .b(div_b),
        .c(div_c), .done(div_done), .q(div_q));

    assign item_take = (state_reg == S_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.value = value_reg;

    // Table read address follows the step counter.
    always_comb
    begin
        raddr = step_reg[AW-1:0];
    end

    // Window of four knots around the interval: i-1 .. i+2.
    function automatic logic [AW-1:0] widx(input logic [AW-1:0] i,
                                           input logic [2:0] k);
        logic signed [AW+2:0] t;
        t = $signed({3'b000, i}) + $signed({{AW{1'b0}}, k}) - 1;
        if (t < 0)
            t = '0;
        widx = t[AW-1:0];
    endfunction

    // Saturating narrow helpers.
    function automatic logic signed [63:0] sat31(input logic signed [63:0] v);
        sat31 = csi_pkg::clamp_sym({{2{v[63]}}, v}, csi_pkg::LIM31);
    endfunction
    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        sadd = csi_pkg::clamp_sym({{2{a[63]}}, a} + {{2{b[63]}}, b}, csi_pkg::LIM62);
    endfunction

    // Final sum of the left knot value and the cubic term.
    assign acc_w = sadd(yw_reg[1], t0_reg);

    // Sequencer. Each division returns through S_DIVW to ret_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            div_start <= 1'b0;
            step_reg  <= '0;
            sub_reg   <= '0;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            div_start <= 1'b0;
            if (ov_reg && out_ch.ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid && !ov_reg && item.command == csi_pkg::CMD_QUERY)
                    begin
                        qx_reg   <= qx_w;
                        last_reg <= AW'(n_clamp - 1'b1);
                        step_reg <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    // Read x[0]/y[0], then x[last]/y[last].
                    if (step_reg == '0)
                    begin
                        x0_reg <= xr_w;
                        y0_reg <= yr_w;
                        step_reg <= CW'(last_reg);
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        xl_reg <= xr_w;
                        yl_reg <= yr_w;
                        state_reg <= S_TRIM;
                    end
                end
                S_TRIM:
                begin
                    if (trim_enable && qx_reg <= x0_reg)
                    begin
                        value_reg <= y0_reg[31:0];
                        state_reg <= S_OUT;
                    end
                    else if (trim_enable && qx_reg >= xl_reg)
                    begin
                        value_reg <= yl_reg[31:0];
                        state_reg <= S_OUT;
                    end
                    else if (qx_reg <= x0_reg)
                    begin
                        i_reg <= '0;
                        state_reg <= S_LOAD;
                        sub_reg <= '0;
                    end
                    else if (qx_reg >= xl_reg)
                    begin
                        i_reg <= last_reg - 1'b1;
                        state_reg <= S_LOAD;
                        sub_reg <= '0;
                    end
                    else
                    begin
                        i_reg <= '0;
                        step_reg <= CW'(1);
                        state_reg <= S_SRCH;
                        sub_reg <= '0;
                    end
                end
                S_SRCH:
                begin
                    // Linear search: read x[i+1] then compare.
                    if (sub_reg == 3'd0)
                        sub_reg <= 3'd1;
                    else if (sub_reg == 3'd1)
                        sub_reg <= 3'd2;
                    else
                    begin
                        sub_reg <= 3'd0;
                        if (i_reg < last_reg - 1'b1 && qx_reg >= xr_w)
                        begin
                            i_reg <= i_reg + 1'b1;
                            step_reg <= step_reg + 1'b1;
                        end
                        else
                            state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    step_reg <= CW'(widx(i_reg, sub_reg));
                    state_reg <= S_LOADW;
                end
                S_LOADW:
                begin
                    state_reg <= S_LOADC;
                end
                S_LOADC:
                begin
                    xw_reg[sub_reg[1:0]] <= xr_w;
                    yw_reg[sub_reg[1:0]] <= yr_w;
                    if (sub_reg == 3'd3)
                    begin
                        sub_reg <= '0;
                        state_reg <= S_SLOPE;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 1'b1;
                        state_reg <= S_LOAD;
                    end
                end
                S_SLOPE:
                begin
                    // Query on the right knot returns its y.
                    if (sub_reg == 3'd0 && qx_reg == xw_reg[2])
                    begin
                        value_reg <= yw_reg[2][31:0];
                        state_reg <= S_OUT;
                    end
                    else if (sub_reg == 3'd3)
                    begin
                        h_reg <= xw_reg[2] - xw_reg[1];
                        u_reg <= qx_reg - xw_reg[1];
                        s_reg <= sl_reg[1];
                        sub_reg <= '0;
                        state_reg <= S_INNER;
                    end
                    else
                    begin
                        // slopes k-1, k, k+1 over the window
                        div_a <= yw_reg[sub_reg[1:0]+2'd1] - yw_reg[sub_reg[1:0]];
                        div_b <= one_fx;
                        div_c <= xw_reg[sub_reg[1:0]+2'd1] - xw_reg[sub_reg[1:0]];
                        div_start <= 1'b1;
                        ret_reg <= S_SLOPE;
                        state_reg <= S_DIVW;
                    end
                end
                S_INNER:
                begin
                    // Inner derivatives at knot i and i+1 from slope pairs.
                    if (sub_reg == 3'd2)
                    begin
                        sub_reg <= '0;
                        state_reg <= S_DERIV;
                    end
                    else if (sl_reg[sub_reg[1:0]] == 0 || sl_reg[sub_reg[1:0]+2'd1] == 0 ||
                             (sl_reg[sub_reg[1:0]][63] != sl_reg[sub_reg[1:0]+2'd1][63]))
                    begin
                        if (sub_reg == 3'd0) fl_reg <= '0; else fr_reg <= '0;
                        sub_reg <= sub_reg + 1'b1;
                    end
                    else
                    begin
                        div_a <= sl_reg[sub_reg[1:0]] <<< 1;
                        div_b <= sl_reg[sub_reg[1:0]+2'd1];
                        div_c <= sl_reg[sub_reg[1:0]] + sl_reg[sub_reg[1:0]+2'd1];
                        div_start <= 1'b1;
                        ret_reg <= S_INNER;
                        state_reg <= S_DIVW;
                    end
                end
                S_DERIV:
                begin
                    // End knots: (3*end slope - neighbour derivative) / 2.
                    if (i_reg == '0)
                        fl_reg <= sat31((3 * sl_reg[1] - fr_reg) / 2);
                    if (i_reg + 1'b1 == last_reg)
                        fr_reg <= sat31((3 * sl_reg[1] - fl_reg) / 2);
                    state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    bq_reg <= 3 * s_reg - fr_reg - 2 * fl_reg;
                    cc_reg <= fl_reg + fr_reg - 2 * s_reg;
                    state_reg <= S_EV1;
                end
                S_EV1:
                begin
                    div_a <= cc_reg; div_b <= u_reg; div_c <= h_reg;
                    div_start <= 1'b1; ret_reg <= S_EV2; state_reg <= S_DIVW;
                    sub_reg <= 3'd4;
                end
                S_EV2:
                begin
                    div_a <= sadd(bq_reg, t0_reg); div_b <= u_reg; div_c <= h_reg;
                    div_start <= 1'b1; ret_reg <= S_EV3; state_reg <= S_DIVW;
                end
                S_EV3:
                begin
                    div_a <= sadd(fl_reg, t0_reg); div_b <= u_reg; div_c <= one_fx;
                    div_start <= 1'b1; ret_reg <= S_SAT; state_reg <= S_DIVW;
                end
                S_SAT:
                begin
                    if (acc_w > 64'sh7FFF_FFFF)
                        value_reg <= 32'sh7FFF_FFFF;
                    else if (acc_w < -64'sh8000_0000)
                        value_reg <= 32'sh8000_0000;
                    else
                        value_reg <= acc_w[31:0];
                    state_reg <= S_OUT;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        state_reg <= ret_reg;
                        if (ret_reg == S_SLOPE)
                        begin
                            sl_reg[sub_reg[1:0]] <= sat31(div_q);
                            sub_reg <= sub_reg + 1'b1;
                        end
                        else if (ret_reg == S_INNER)
                        begin
                            if (sub_reg == 3'd0) fl_reg <= sat31(div_q);
                            else fr_reg <= sat31(div_q);
                            sub_reg <= sub_reg + 1'b1;
                        end
                        else
                            t0_reg <= div_q;
                    end
                end
                S_OUT:
                begin
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ch.ready) |=> ov_reg && $stable(value_reg))
        else $error("result lost before it was taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> !ov_reg)
        else $error("result overwritten");
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench of the constrained spline interpolator.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int unsigned CYCLE_LIMIT = 6000000;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned TABLE_DEPTH = 16;
    localparam longint ONE_Q = 64'sd65536;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    csi_in_if  in_if ();
    csi_out_if out_if ();

    constrained_spline_interpolator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the knot tables and registers.
    longint      knot_xs [TABLE_DEPTH];
    longint      knot_ys [TABLE_DEPTH];
    logic        trim_on;
    logic [4:0]  count_reg;

    logic [31:0] value_queue [$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Clock.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Saturate to a symmetric limit.
    function automatic longint sat_sym(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // trunc(a*b/c) saturated to the 62-bit limit; zero divisor gives zero.
    function automatic longint mul_div(input longint a, input longint b, input longint c);
        logic [127:0] prod;
        logic [127:0] quo;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [63:0]  uc;
        logic         neg;
        if (c == 0)
            return 0;
        neg = ((a < 0) != (b < 0)) != (c < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        uc = (c < 0) ? -c : c;
        prod = {64'd0, ua} * {64'd0, ub};
        quo = prod / {64'd0, uc};
        if (quo > {64'd0, csi_pkg::LIM62})
            quo = {64'd0, csi_pkg::LIM62};
        return neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
    endfunction

    function automatic longint seg_slope(input int k);
        return sat_sym(mul_div(knot_ys[k+1] - knot_ys[k], ONE_Q,
                               knot_xs[k+1] - knot_xs[k]), csi_pkg::LIM31);
    endfunction

    // Harmonic mean of neighbor slopes, zero on a sign change or a flat side.
    function automatic longint inner_slope(input int k);
        longint s0;
        longint s1;
        s0 = seg_slope(k - 1);
        s1 = seg_slope(k);
        if (s0 == 0 || s1 == 0 || ((s0 < 0) != (s1 < 0)))
            return 0;
        return sat_sym(mul_div(2 * s0, s1, s0 + s1), csi_pkg::LIM31);
    endfunction

    function automatic longint knot_slope(input int k, input int last);
        if (k == 0)
            return sat_sym((3 * seg_slope(0) - inner_slope(1)) / 2, csi_pkg::LIM31);
        if (k == last)
            return sat_sym((3 * seg_slope(last - 1) - inner_slope(last - 1)) / 2,
                           csi_pkg::LIM31);
        return inner_slope(k);
    endfunction

    // Expected spline value at one query point.
    function automatic logic [31:0] spline_value(input logic [31:0] qbits);
        int     n;
        int     last;
        int     i;
        longint qx;
        longint h;
        longint s;
        longint fl;
        longint fr;
        longint bq;
        longint cc;
        longint u;
        longint acc;
        n = (count_reg < 3) ? 3 : ((count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg);
        last = n - 1;
        qx = longint'($signed(qbits));
        if (trim_on) begin
            if (qx <= knot_xs[0])
                return knot_ys[0][31:0];
            if (qx >= knot_xs[last])
                return knot_ys[last][31:0];
        end
        i = 0;
        if (qx <= knot_xs[0])
            i = 0;
        else if (qx >= knot_xs[last])
            i = last - 1;
        else
            while (i < last - 1 && qx >= knot_xs[i+1])
                i++;
        if (qx == knot_xs[i+1])
            return knot_ys[i+1][31:0];
        h = knot_xs[i+1] - knot_xs[i];
        s = seg_slope(i);
        fl = knot_slope(i, last);
        fr = knot_slope(i + 1, last);
        bq = 3 * s - fr - 2 * fl;
        cc = fl + fr - 2 * s;
        u = qx - knot_xs[i];
        acc = sat_sym(bq + mul_div(cc, u, h), csi_pkg::LIM62);
        acc = sat_sym(fl + mul_div(acc, u, h), csi_pkg::LIM62);
        acc = sat_sym(knot_ys[i] + mul_div(acc, u, ONE_Q), csi_pkg::LIM62);
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        else if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    // Send one item, with a random gap first; predict on acceptance.
    task automatic send_item(input logic cmd, input logic [3:0] idx,
                             input logic [31:0] kx, input logic [31:0] ky,
                             input logic [31:0] qx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge clk);
        end
        in_if.valid = 1'b1;
        in_if.command = cmd;
        in_if.knot_index = idx;
        in_if.knot_x = kx;
        in_if.knot_y = ky;
        in_if.query_x = qx;
        do
            @(posedge clk);
        while (!in_if.ready);
        if (cmd == csi_pkg::CMD_WRITE) begin
            knot_xs[idx] = longint'($signed(kx));
            knot_ys[idx] = longint'($signed(ky));
        end else begin
            value_queue.push_back(spline_value(qx));
        end
        @(negedge clk);
    endtask

    task automatic write_knot(input int idx, input longint kx, input longint ky);
        send_item(csi_pkg::CMD_WRITE, idx[3:0], kx[31:0], ky[31:0], $urandom);
    endtask

    task automatic query_at(input longint qx);
        send_item(csi_pkg::CMD_QUERY, 4'($urandom), $urandom, $urandom, qx[31:0]);
    endtask

    // Wait until every expected value has come, then let the engine settle.
    task automatic drain();
        in_if.valid = 1'b0;
        while (value_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic reg_write(input logic [0:0] idx, input logic [31:0] data);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == csi_pkg::REG_TRIM)
            trim_on = data[0];
        else
            count_reg = data[4:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Fill all slots with an increasing table, or with noise now and then.
    task automatic load_table();
        longint steps [TABLE_DEPTH];
        longint total;
        longint x;
        longint y;
        int     max_step;
        int     mode;
        int     order [TABLE_DEPTH];
        mode = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: max_step = 16;
            1: max_step = 65536;
            2: max_step = 1 << 20;
            default: max_step = 1 << 27;
        endcase
        total = 0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            steps[k] = $urandom_range(1, max_step);
            total += steps[k];
        end
        x = -64'sd2147483648 + (longint'($urandom) % (64'sd4294967296 - total));
        y = longint'($signed($urandom));
        for (int k = 0; k < TABLE_DEPTH; k++)
            order[k] = k;
        if ($urandom_range(0, 3) == 0)
            order.shuffle();
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (k > 0)
                x += steps[k];
            knot_xs[k] = x;
            if (mode < 40)
                y = longint'($signed($urandom));
            else if (mode < 55)
                y = y;
            else
                y = longint'($signed($urandom_range(0, 1 << 20))) - 64'sd524288
                    + ((k % 5 == 0) ? 64'sd0 : y) / 2;
            knot_ys[k] = y;
        end
        // Noise tables are not increasing.
        if (mode >= 92)
            for (int k = 0; k < TABLE_DEPTH; k++)
                knot_xs[k] = longint'($signed($urandom));
        for (int k = 0; k < TABLE_DEPTH; k++)
            write_knot(order[k], knot_xs[order[k]], knot_ys[order[k]]);
    endtask

    // Query point drawn near the active table, or anywhere now and then.
    task automatic random_query();
        int     last;
        int     i;
        int     r;
        longint qx;
        last = ((count_reg < 3) ? 3 : ((count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg)) - 1;
        i = $urandom_range(0, last - 1);
        r = $urandom_range(0, 99);
        if (r < 60 && knot_xs[i+1] > knot_xs[i])
            qx = knot_xs[i] + (longint'($urandom) % (knot_xs[i+1] - knot_xs[i] + 1));
        else if (r < 70)
            qx = knot_xs[$urandom_range(0, last)];
        else if (r < 80)
            qx = knot_xs[0] - $urandom_range(0, 1 << 20);
        else if (r < 90)
            qx = knot_xs[last] + $urandom_range(0, 1 << 20);
        else
            qx = longint'($signed($urandom));
        if (qx > 64'sd2147483647)
            qx = 64'sd2147483647;
        if (qx < -64'sd2147483648)
            qx = -64'sd2147483648;
        query_at(qx);
    endtask

    // Field extremes, knot hits, flat and sign-changing slopes, trim off,
    // degenerate interval and out-of-range knot counts.
    task automatic test_directed();
        for (int k = 0; k < TABLE_DEPTH; k++)
            write_knot(k, (k == 0) ? -64'sd2147483648 :
                          (k == 15) ? 64'sd2147483647 : -64'sd2000000000 + k * 64'sd250000000,
                       (k == 0) ? 64'sd2147483647 : (k == 15) ? -64'sd2147483648 :
                       (k >= 4 && k <= 6) ? 64'sd65536 : ((k % 2) ? 64'sd3000000 : -64'sd3000000));
        query_at(-64'sd2147483648);
        query_at(64'sd2147483647);
        query_at(64'sd125000000);
        query_at(knot_xs[5]);
        drain();
        reg_write(csi_pkg::REG_TRIM, 32'd0);
        query_at(-64'sd1000000000);
        query_at(64'sd2147483647);
        write_knot(0, -64'sd2100000000, 64'sd0);
        query_at(-64'sd2147483648);
        write_knot(3, knot_xs[2], 64'sd100000);
        query_at(knot_xs[2] + 64'sd1000);
        drain();
        reg_write(csi_pkg::REG_COUNT, 32'd31);
        query_at(64'sd2000000000);
        drain();
        reg_write(csi_pkg::REG_COUNT, 32'd0);
        query_at(64'sd2147483647);
        query_at(knot_xs[1] + 64'sd5);
        drain();
        reg_write(csi_pkg::REG_TRIM, 32'd1);
        reg_write(csi_pkg::REG_COUNT, 32'd3);
        query_at(knot_xs[1] + 64'sd7);
        drain();
    endtask

    // One idling profile across several register settings.
    task automatic test_random_phase(input int unsigned s_pct, input int unsigned r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int set = 0; set < 10; set++) begin
            drain();
            reg_write(csi_pkg::REG_TRIM, $urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0: reg_write(csi_pkg::REG_COUNT, 32'd3);
                1: reg_write(csi_pkg::REG_COUNT, 32'd16);
                2: reg_write(csi_pkg::REG_COUNT, $urandom_range(0, 31));
                default: reg_write(csi_pkg::REG_COUNT, $urandom_range(3, 16));
            endcase
            load_table();
            for (int q = 0; q < 27; q++) begin
                if ($urandom_range(0, 19) == 0)
                    write_knot($urandom_range(0, 15), longint'($signed($urandom)),
                               longint'($signed($urandom)));
                else
                    random_query();
            end
        end
        drain();
    endtask

    // Receiver: stall at random.
    always @(negedge clk)
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each accepted value with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (value_queue.size() == 0) begin
                $display("%0t: unexpected value %h", $time, out_if.value);
                error_count++;
            end else begin
                if (out_if.value !== value_queue[0]) begin
                    $display("%0t: value expected %h actual %h", $time,
                             value_queue[0], out_if.value);
                    error_count++;
                end
                void'(value_queue.pop_front());
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        trim_on = 1'b1;
        count_reg = 5'd16;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            knot_xs[k] = 0;
            knot_ys[k] = 0;
        end
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.command = csi_pkg::CMD_WRITE;
        in_if.knot_index = '0;
        in_if.knot_x = '0;
        in_if.knot_y = '0;
        in_if.query_x = '0;
        out_if.ready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phase(24, 84);
        test_random_phase(84, 24);
        test_random_phase(0, 0);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
